// File: src/hash_map_sorted_buckets_unit_assert.svh
// Assertion macros for the sorted-bucket hash map.
`ifndef HASH_MAP_SORTED_BUCKETS_UNIT_ASSERT_SVH
`define HASH_MAP_SORTED_BUCKETS_UNIT_ASSERT_SVH
`ifndef SYNTH
`define HM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HM_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define HM_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define HM_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

// File: src/hmsb_pkg.sv
// ---------------------------------------------------------------------------
// hmsb_pkg
// Types, codes and constants of the sorted-bucket hash map.
// ---------------------------------------------------------------------------
`default_nettype none
package hmsb_pkg;
    localparam int NUM_BUCKETS_DEF  = 256;
    localparam int BUCKET_DEPTH_DEF = 8;
    localparam int HASH_BITS        = 32;
    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [1:0] MAP_MOD   = 2'd0;
    localparam logic [1:0] MAP_MASK  = 2'd1;
    localparam logic [1:0] MAP_MUL   = 2'd2;
    localparam logic [1:0] MAP_SPARE = 2'd3;

    localparam logic REG_MAP_MODE = 1'b0;
    localparam logic REG_BUCKETS  = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value_out;
        logic [11:0] entry_total;
    } t_rsp;
endpackage
`default_nettype wire

// File: src/hash_map_sorted_buckets_unit.sv
// ---------------------------------------------------------------------------
// hash_map_sorted_buckets_unit
// Key-value map: FNV-1a hash, configurable bucket mapping, sorted buckets.
// ---------------------------------------------------------------------------
// Usage. Request words (command, key, value_in) arrive on i_req_valid /
// o_req_ready; one response word per request leaves on o_rsp_valid /
// i_rsp_ready. Registers are written through i_cfg_valid / o_cfg_ready with
// an index (0 map_mode, 1 bucket_count) and data; writes are always taken.
// One request at a time is worked on. After acceptance the key is hashed
// (one FNV byte a cycle), then the bucket mapping is set up and applied:
// directly (mask), by a multiply, or by a restoring divider (modulo and the
// spare code, one bit a cycle). Next the bucket fill is read and a binary
// search probes the bucket; insert or remove then moves entries one slot at
// a time, and last the entry and fill are written back and the response loaded.
// The response sits in an output register; the next request is taken
// while it waits, and work stalls only when a new response must be loaded.
// Reset clears control state, keys_held and the per-bucket fill valid bits.
`default_nettype none
`include "hash_map_sorted_buckets_unit_assert.svh"
module hash_map_sorted_buckets_unit #(
    parameter int NUM_BUCKETS  = hmsb_pkg::NUM_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = hmsb_pkg::BUCKET_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire hmsb_pkg::t_req i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output hmsb_pkg::t_rsp     o_rsp,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [8:0]    i_cfg_data
);
    localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int DW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int AW = BW + DW;
    localparam int SD = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int NW = $clog2(NUM_BUCKETS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_HASH, S_MAP, S_DIV, S_MUL, S_FILL, S_LATCH, S_PROBE, S_CMP,
        S_MOVE_RD, S_MOVE_WR, S_PUT, S_DONE
    } t_state;

    // Memories: keys and values, one write and one registered read each.
    logic [31:0] key_mem [SD];
    logic [31:0] val_mem [SD];
    logic [FW-1:0] fill_mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_fill_ok;

    t_state        r_state;
    logic [1:0]    r_mode;
    logic [8:0]    r_count;
    hmsb_pkg::t_req r_req;
    logic [31:0]   r_hash;
    logic [1:0]    r_byte;
    logic [NW-1:0] r_n;
    logic [31:0]   r_rem;
    logic [5:0]    r_dbit;
    logic [NW+31:0] r_prod;
    logic [BW-1:0] r_bkt;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] r_lo, r_hi, r_mid, r_pos, r_mv;
    logic          r_hit;
    logic [31:0]   r_found;
    logic [11:0]   r_held;
    logic          r_rsp_valid;
    hmsb_pkg::t_rsp r_rsp;

    // Memory ports.
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [31:0]   m_wkey, m_wval, r_rkey, r_rval;
    logic          f_we;
    logic [FW-1:0] f_wdata, r_ffill;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            key_mem[m_waddr] <= m_wkey;
            val_mem[m_waddr] <= m_wval;
        end
        r_rkey <= key_mem[m_raddr];
        r_rval <= val_mem[m_raddr];
        if (f_we) fill_mem[r_bkt] <= f_wdata;
        r_ffill <= fill_mem[r_bkt];
    end

    function automatic logic [AW-1:0] slot(input logic [BW-1:0] b, input logic [FW-1:0] s);
        slot = AW'(b) * AW'(BUCKET_DEPTH) + AW'(s);
    endfunction

    // Live bucket count from the registers.
    logic [NW-1:0] cnt_clamp, cnt_live;
    always_comb begin
        cnt_clamp = (r_count == 9'd0) ? NW'(1)
                  : ({23'd0, r_count} > NUM_BUCKETS) ? NW'(NUM_BUCKETS) : NW'(r_count);
        cnt_live = cnt_clamp;
        if (r_mode == hmsb_pkg::MAP_MASK) begin
            cnt_live = NW'(1);
            for (int i = 0; i < NW; i++)
                if ((NW'(1) << i) < cnt_clamp) cnt_live = NW'(1) << (i + 1);
            if ({{(32-NW){1'b0}}, cnt_live} > NUM_BUCKETS) cnt_live = cnt_live >> 1;
        end
    end

    // A bucket whose fill was never written reads as empty.
    logic [32:0]   div_try;
    logic [7:0]    hbyte;
    logic [FW-1:0] fill_rd;
    always_comb begin
        div_try = {r_rem, r_hash[31]} - {{(33-NW){1'b0}}, r_n};
        hbyte   = 8'(r_req.key >> {r_byte, 3'b000});
        fill_rd = r_fill_ok[r_bkt] ? ((r_ffill > FW'(BUCKET_DEPTH)) ? FW'(BUCKET_DEPTH)
                  : r_ffill) : '0;
    end

    logic          rsp_free;
    logic [1:0]    fin_status;
    logic [31:0]   fin_val;
    logic [11:0]   fin_held;
    assign rsp_free    = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        m_we = 1'b0; m_waddr = '0; m_wkey = r_req.key; m_wval = r_req.value_in;
        m_raddr = slot(r_bkt, r_mid);
        f_we = 1'b0; f_wdata = r_fill;
        case (r_state)
            S_PROBE:   m_raddr = slot(r_bkt, r_mid);
            S_MOVE_RD: m_raddr = slot(r_bkt, r_mv);
            S_MOVE_WR: begin
                m_we = 1'b1; m_wkey = r_rkey; m_wval = r_rval;
                m_waddr = (r_req.command == hmsb_pkg::CMD_INSERT)
                        ? slot(r_bkt, r_mv + FW'(1)) : slot(r_bkt, r_mv - FW'(1));
            end
            S_PUT: begin
                if (r_req.command == hmsb_pkg::CMD_INSERT &&
                    (r_hit || r_fill < FW'(BUCKET_DEPTH))) begin
                    m_we = 1'b1; m_waddr = slot(r_bkt, r_pos);
                end
                if (r_req.command == hmsb_pkg::CMD_INSERT && !r_hit &&
                    r_fill < FW'(BUCKET_DEPTH)) begin
                    f_we = 1'b1; f_wdata = r_fill + FW'(1);
                end
                if (r_req.command == hmsb_pkg::CMD_REMOVE && r_hit) begin
                    f_we = 1'b1; f_wdata = r_fill - FW'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        fin_status = hmsb_pkg::ST_ABSENT; fin_val = '0; fin_held = r_held;
        case (r_req.command)
            hmsb_pkg::CMD_INSERT: begin
                if (r_hit) fin_status = hmsb_pkg::ST_OK;
                else if (r_fill >= FW'(BUCKET_DEPTH)) fin_status = hmsb_pkg::ST_FULL;
                else begin fin_status = hmsb_pkg::ST_OK; fin_held = r_held + 12'd1; end
            end
            hmsb_pkg::CMD_REMOVE: if (r_hit) begin
                fin_status = hmsb_pkg::ST_OK; fin_val = r_found;
                if (r_held != 12'd0) fin_held = r_held - 12'd1;
            end
            default: if (r_hit) begin fin_status = hmsb_pkg::ST_OK; fin_val = r_found; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_mode <= hmsb_pkg::MAP_MOD; r_count <= 9'd256;
            r_held <= '0; r_rsp_valid <= 1'b0; r_fill_ok <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == hmsb_pkg::REG_MAP_MODE) r_mode <= i_cfg_data[1:0];
                else r_count <= i_cfg_data;
            end
            r_rsp_valid <= (r_rsp_valid && !i_rsp_ready) || (r_state == S_DONE && rsp_free);
            case (r_state)
                S_IDLE: if (i_req_valid) begin
                    r_req <= i_req; r_hash <= hmsb_pkg::FNV_BASIS; r_byte <= '0;
                    r_state <= S_HASH;
                end
                S_HASH: begin
                    r_hash <= 32'((r_hash ^ {24'd0, hbyte}) * hmsb_pkg::FNV_PRIME);
                    r_byte <= r_byte + 2'd1;
                    if (r_byte == 2'd3) r_state <= S_MAP;
                end
                S_MAP: begin
                    r_n <= cnt_live; r_rem <= '0; r_dbit <= '0;
                    if (r_mode == hmsb_pkg::MAP_MASK) begin
                        r_bkt <= BW'(r_hash & (32'(cnt_live) - 32'd1)); r_state <= S_FILL;
                    end else if (r_mode == hmsb_pkg::MAP_MUL) begin
                        r_prod <= (NW+32)'(r_hash) * (NW+32)'(cnt_live);
                        r_state <= S_MUL;
                    end else r_state <= S_DIV;
                end
                S_DIV: begin
                    r_hash <= {r_hash[30:0], 1'b0};
                    r_rem  <= div_try[32] ? {r_rem[30:0], r_hash[31]} : div_try[31:0];
                    r_dbit <= r_dbit + 6'd1;
                    if (r_dbit == 6'd31) begin
                        r_bkt <= BW'(div_try[32] ? {r_rem[30:0], r_hash[31]} : div_try[31:0]);
                        r_state <= S_FILL;
                    end
                end
                S_MUL: begin r_bkt <= BW'(r_prod[NW+31:32]); r_state <= S_FILL; end
                // The fill read of the new bucket lands at the end of this cycle.
                S_FILL: r_state <= S_LATCH;
                S_LATCH: begin
                    r_fill <= fill_rd; r_hi <= fill_rd; r_mid <= fill_rd >> 1;
                    r_lo <= '0; r_hit <= 1'b0;
                    r_state <= S_PROBE;
                end
                S_PROBE: r_state <= S_CMP;
                S_CMP: begin
                    if (r_lo >= r_hi) begin
                        r_pos <= r_lo;
                        r_mv <= (r_req.command == hmsb_pkg::CMD_INSERT) ? r_fill - FW'(1)
                              : r_lo + FW'(1);
                        if (r_req.command == hmsb_pkg::CMD_INSERT && !r_hit &&
                            r_fill < FW'(BUCKET_DEPTH) && r_fill != r_lo)
                            r_state <= S_MOVE_RD;
                        else if (r_req.command == hmsb_pkg::CMD_REMOVE && r_hit &&
                                 r_lo + FW'(1) < r_fill)
                            r_state <= S_MOVE_RD;
                        else
                            r_state <= S_PUT;
                    end else if (r_req.key < r_rkey) begin
                        r_hi <= r_mid; r_mid <= r_lo + ((r_mid - r_lo) >> 1);
                        r_state <= S_PROBE;
                    end else if (r_req.key > r_rkey) begin
                        r_lo <= r_mid + FW'(1);
                        r_mid <= r_mid + FW'(1) + ((r_hi - r_mid - FW'(1)) >> 1);
                        r_state <= S_PROBE;
                    end else begin
                        // Keep the found data; entry moves reuse the read port.
                        r_hit <= 1'b1; r_found <= r_rval; r_lo <= r_mid; r_hi <= r_mid;
                        r_state <= S_PROBE;
                    end
                end
                S_MOVE_RD: r_state <= S_MOVE_WR;
                S_MOVE_WR: begin
                    if (r_req.command == hmsb_pkg::CMD_INSERT) begin
                        if (r_mv == r_pos) r_state <= S_PUT;
                        else begin r_mv <= r_mv - FW'(1); r_state <= S_MOVE_RD; end
                    end else begin
                        if (r_mv + FW'(1) >= r_fill) r_state <= S_PUT;
                        else begin r_mv <= r_mv + FW'(1); r_state <= S_MOVE_RD; end
                    end
                end
                S_PUT: begin
                    if (f_we) r_fill_ok[r_bkt] <= 1'b1;
                    r_state <= S_DONE;
                end
                S_DONE: if (rsp_free) begin
                    r_rsp <= '{status: fin_status, value_out: fin_val, entry_total: fin_held};
                    r_held <= fin_held;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `HM_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, o_rsp_valid && !i_rsp_ready, o_rsp_valid, "rsp lost")
    `HM_ASSERT_IMPL(a_one_req, i_clk, i_rst_n, (o_req_ready |-> r_state == S_IDLE), "ready not idle")
    `HM_ASSERT_IMPL(a_held_max, i_clk, i_rst_n, (r_held <= 12'(SD)), "key count too big")
endmodule
`default_nettype wire

// File: tb/sv/hash_map_sorted_buckets_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// hash_map_sorted_buckets_unit_tb
// Self-checking bench for the sorted-bucket hash map. A scoreboard keeps its
// own copy of the buckets and predicts each response word. It is driven with
// directed words, then with random words under several bucket mappings,
// random idling on both channels and one long response stall.
// ---------------------------------------------------------------------------
`default_nettype none
module hash_map_sorted_buckets_unit_tb;
    localparam int NB         = hmsb_pkg::NUM_BUCKETS_DEF;
    localparam int DEPTH      = hmsb_pkg::BUCKET_DEPTH_DEF;
    localparam int POOL_SIZE  = 40;
    localparam int PHASE_LEN  = 150;
    localparam int CYCLE_CAP  = 1000000;

    // Scoreboard: a shadow copy of the map. Every accepted request word is
    // applied to the shadow copy at once, and the response it must produce is
    // queued. Responses leave the block in request order.
    class hash_map_scoreboard;
        logic [31:0] key_mem [NB*DEPTH];
        logic [31:0] val_mem [NB*DEPTH];
        int          bucket_used [NB];
        logic [11:0] keys_held;
        logic [1:0]  map_mode;
        logic [8:0]  bucket_count;
        hmsb_pkg::t_rsp expected_rsp [$];
        int          mismatches;

        function new();
            foreach (bucket_used[i]) bucket_used[i] = 0;
            keys_held    = '0;
            map_mode     = hmsb_pkg::MAP_MOD;
            bucket_count = 9'd256;
            mismatches   = 0;
        endfunction

        function void write_reg(logic idx, logic [8:0] data);
            if (idx == hmsb_pkg::REG_MAP_MODE) map_mode = data[1:0];
            else bucket_count = data;
        endfunction

        function logic [31:0] fnv1a(logic [31:0] k);
            logic [31:0] h;
            h = hmsb_pkg::FNV_BASIS;
            for (int i = 0; i < 4; i++) begin
                h = h ^ {24'd0, k[8*i +: 8]};
                h = h * hmsb_pkg::FNV_PRIME;
            end
            return h;
        endfunction

        function int bucket_of(logic [31:0] k);
            logic [31:0] h;
            logic [63:0] prod;
            int n;
            int p;
            int b;
            h = fnv1a(k);
            n = bucket_count;
            if (n < 1) n = 1;
            if (n > NB) n = NB;
            if (map_mode == hmsb_pkg::MAP_MASK) begin
                p = 1;
                while (p < n) p = p << 1;
                while (p > NB) p = p >> 1;
                n = p;
                b = int'(h & (n - 1));
            end else if (map_mode == hmsb_pkg::MAP_MUL) begin
                prod = {32'd0, h} * 64'(n);
                b = int'(prod[63:32]);
            end else begin
                // Mode three falls back to modulo.
                b = int'(h % n);
            end
            return (b < NB) ? b : 0;
        endfunction

        function void note_request(hmsb_pkg::t_req r);
            hmsb_pkg::t_rsp rsp;
            int b;
            int base;
            int fill;
            int lo;
            int hi;
            int mid;
            bit hit;
            b    = bucket_of(r.key);
            base = b * DEPTH;
            fill = bucket_used[b];
            lo   = 0;
            hi   = fill;
            hit  = 0;
            // Binary search for the lowest slot whose key is not below the key.
            while (lo < hi && !hit) begin
                mid = lo + ((hi - lo) >> 1);
                if (r.key < key_mem[base+mid]) hi = mid;
                else if (r.key > key_mem[base+mid]) lo = mid + 1;
                else begin
                    hit = 1;
                    lo  = mid;
                end
            end
            rsp.status    = hmsb_pkg::ST_ABSENT;
            rsp.value_out = '0;
            if (r.command == hmsb_pkg::CMD_INSERT) begin
                if (hit) begin
                    val_mem[base+lo] = r.value_in;
                    rsp.status = hmsb_pkg::ST_OK;
                end else if (fill >= DEPTH) begin
                    rsp.status = hmsb_pkg::ST_FULL;
                end else begin
                    for (int i = fill; i > lo; i--) begin
                        key_mem[base+i] = key_mem[base+i-1];
                        val_mem[base+i] = val_mem[base+i-1];
                    end
                    key_mem[base+lo] = r.key;
                    val_mem[base+lo] = r.value_in;
                    bucket_used[b]   = fill + 1;
                    keys_held        = keys_held + 1;
                    rsp.status       = hmsb_pkg::ST_OK;
                end
            end else if (r.command == hmsb_pkg::CMD_REMOVE) begin
                if (hit) begin
                    rsp.value_out = val_mem[base+lo];
                    for (int i = lo; i < fill - 1; i++) begin
                        key_mem[base+i] = key_mem[base+i+1];
                        val_mem[base+i] = val_mem[base+i+1];
                    end
                    bucket_used[b] = fill - 1;
                    if (keys_held != 0) keys_held = keys_held - 1;
                    rsp.status = hmsb_pkg::ST_OK;
                end
            end else if (hit) begin
                // Search, and the unused command code that behaves as one.
                rsp.value_out = val_mem[base+lo];
                rsp.status    = hmsb_pkg::ST_OK;
            end
            rsp.entry_total = keys_held;
            expected_rsp.push_back(rsp);
        endfunction

        function void check_response(hmsb_pkg::t_rsp got);
            hmsb_pkg::t_rsp want;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: response word with none expected: %p", got);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.value_out !== want.value_out ||
                got.entry_total !== want.entry_total) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: status %0d/%0d value %h/%h total %0d/%0d (exp/act)",
                             want.status, got.status, want.value_out, got.value_out,
                             want.entry_total, got.entry_total);
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_req_valid;
    logic   o_req_ready;
    hmsb_pkg::t_req i_req;
    logic   o_rsp_valid;
    logic   i_rsp_ready;
    hmsb_pkg::t_rsp o_rsp;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    logic   i_cfg_index;
    logic [8:0] i_cfg_data;

    hash_map_scoreboard map_sb;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    int          cycle_count;
    logic [31:0] key_pool [POOL_SIZE];

    hash_map_sorted_buckets_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog. The slowest legal run is far below this count.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Response side: check each accepted word, then pick the next ready.
    // A long hold keeps ready low so the block fills and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) map_sb.check_response(o_rsp);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_rsp_ready <= 1'b0;
            end else begin
                i_rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one request word; valid stays high until it is taken.
    task automatic send_request(hmsb_pkg::t_req r);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        map_sb.note_request(r);
    endtask

    task automatic send_word(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
        hmsb_pkg::t_req r;
        r.command  = cmd;
        r.key      = k;
        r.value_in = v;
        send_request(r);
    endtask

    // Stop offering and wait until every expected response has come back,
    // plus some slack for work still in flight.
    task automatic drain_responses();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (map_sb.expected_rsp.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Registers are written only while the block is idle.
    task automatic write_reg(logic idx, logic [8:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        map_sb.write_reg(idx, data);
    endtask

    // Random words mostly reuse a small pool of keys, so hits, updates,
    // removals of present keys and full buckets are common.
    function automatic hmsb_pkg::t_req random_request();
        hmsb_pkg::t_req r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) r.command = hmsb_pkg::CMD_INSERT;
        else if (pick < 70) r.command = hmsb_pkg::CMD_SEARCH;
        else if (pick < 95) r.command = hmsb_pkg::CMD_REMOVE;
        else r.command = hmsb_pkg::CMD_SPARE;
        if ($urandom_range(0, 99) < 85) r.key = key_pool[$urandom_range(0, POOL_SIZE-1)];
        else r.key = $urandom;
        r.value_in = $urandom;
        return r;
    endfunction

    initial begin
        logic [1:0] phase_mode  [7];
        logic [8:0] phase_count [7];
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_req_valid   = 1'b0;
        i_req         = '0;
        i_rsp_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = hmsb_pkg::REG_MAP_MODE;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        cycle_count   = 0;
        map_sb        = new();
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: one bucket, so every key lands in it. Keys arrive
        // out of order to exercise the shifting, then the bucket overflows.
        write_reg(hmsb_pkg::REG_BUCKETS, 9'd1);
        send_word(hmsb_pkg::CMD_SEARCH, 32'd5, 32'hFFFF_FFFF);
        send_word(hmsb_pkg::CMD_INSERT, 32'd5, 32'h0000_0000);
        send_word(hmsb_pkg::CMD_INSERT, 32'd3, 32'hFFFF_FFFF);
        send_word(hmsb_pkg::CMD_INSERT, 32'd9, 32'h1234_5678);
        send_word(hmsb_pkg::CMD_INSERT, 32'd1, 32'hA5A5_A5A5);
        send_word(hmsb_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_word(hmsb_pkg::CMD_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_word(hmsb_pkg::CMD_INSERT, 32'd7, 32'h0000_0007);
        send_word(hmsb_pkg::CMD_INSERT, 32'd8, 32'h0000_0008);
        send_word(hmsb_pkg::CMD_INSERT, 32'd100, 32'hDEAD_BEEF);  // bucket full: dropped
        send_word(hmsb_pkg::CMD_INSERT, 32'd3, 32'hCAFE_F00D);    // update still allowed
        send_word(hmsb_pkg::CMD_SEARCH, 32'd3, 32'd0);
        send_word(hmsb_pkg::CMD_SEARCH, 32'd4, 32'd0);
        send_word(hmsb_pkg::CMD_SPARE, 32'd9, 32'hFFFF_FFFF);     // unused code searches
        send_word(hmsb_pkg::CMD_REMOVE, 32'd0, 32'd0);
        send_word(hmsb_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'd0);
        send_word(hmsb_pkg::CMD_REMOVE, 32'd4, 32'd0);
        send_word(hmsb_pkg::CMD_INSERT, 32'd2, 32'hFFFF_FFFF);
        send_word(hmsb_pkg::CMD_SEARCH, 32'd2, 32'd0);
        send_word(hmsb_pkg::CMD_REMOVE, 32'd1, 32'd0);
        drain_responses();

        // Random phases. Settings include clamped counts, a count that rounds
        // up, the unused mapping code and reconfiguration with keys still held.
        phase_mode[0] = hmsb_pkg::MAP_MOD;   phase_count[0] = 9'd256;
        phase_mode[1] = hmsb_pkg::MAP_MASK;  phase_count[1] = 9'd5;
        phase_mode[2] = hmsb_pkg::MAP_MUL;   phase_count[2] = 9'd2;
        phase_mode[3] = hmsb_pkg::MAP_MOD;   phase_count[3] = 9'd3;
        phase_mode[4] = hmsb_pkg::MAP_MASK;  phase_count[4] = 9'd0;
        phase_mode[5] = hmsb_pkg::MAP_SPARE; phase_count[5] = 9'd511;
        phase_mode[6] = hmsb_pkg::MAP_MUL;   phase_count[6] = 9'd300;

        for (int ph = 0; ph < 7; ph++) begin
            write_reg(hmsb_pkg::REG_MAP_MODE, 9'(phase_mode[ph]));
            write_reg(hmsb_pkg::REG_BUCKETS, phase_count[ph]);
            for (int i = 2; i < POOL_SIZE; i += 2) key_pool[i] = $urandom;
            if (ph < 2) begin
                send_idle_pct = 34;
                recv_idle_pct = 58;
            end else if (ph < 4) begin
                send_idle_pct = 58;
                recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Hold responses off for a long stretch while requests keep coming.
            if (ph == 1) hold_left = 400;
            for (int n = 0; n < PHASE_LEN; n++) send_request(random_request());
            drain_responses();
        end

        if (map_sb.mismatches == 0 && map_sb.expected_rsp.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
